>>> hdl/packet_ring_queue_admission_assert.svh
// Assertion macros shared by the packet ring queue admission RTL.
`ifndef PACKET_RING_QUEUE_ADMISSION_ASSERT_SVH
`define PACKET_RING_QUEUE_ADMISSION_ASSERT_SVH

// The condition must never hold while out of reset.
`define PRQA_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

// When the trigger holds, the consequence must hold in the following cycle.
`define PRQA_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("%m: expected follow-up did not occur");

`endif

>>> hdl/prqa_pkg.sv
// Package with shared types and constants of the packet ring queue admission block.
`timescale 1ns / 1ps
`default_nettype none

package prqa_pkg;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 12;
    localparam int FREE_W = 12;

    typedef enum logic
    {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef struct packed
    {
        logic wr_en;
        logic rd_en;
    } mem_req_t;

    typedef struct packed
    {
        logic              read_valid;
        logic              packet_accepted;
        logic [FREE_W-1:0] free_space;
    } step_result_t;

endpackage

`default_nettype wire

>>> hdl/packet_ring_queue_admission.sv
// Top level of the byte-wide packet ring queue with whole-packet admission.
`timescale 1ns / 1ps
`default_nettype none
`include "packet_ring_queue_admission_assert.svh"

// Byte-wide circular packet buffer of BUFFER_BYTES entries. Push words store
// packet bytes; a packet is admitted on its first byte only if its length is
// strictly below the free space, otherwise all its bytes are dropped. Pop words
// return the oldest byte or read_valid low when the buffer is empty. Every word
// yields exactly one result carrying the free space after that word. The block
// takes one word per clock while in_ready is high; in_ready drops when the stage
// and output registers both hold results and out_ready is low. A result passes
// the registered read port of the byte memory and then the output register. The
// memory needs no initialization after reset.
module packet_ring_queue_admission #(
    parameter int BUFFER_BYTES = 2048
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         func,
    input  wire logic [prqa_pkg::DATA_W-1:0]  data_byte,
    input  wire logic                         start_of_packet,
    input  wire logic [prqa_pkg::LEN_W-1:0]   packet_length,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [prqa_pkg::DATA_W-1:0]  read_data,
    output logic                              read_valid,
    output logic                              packet_accepted,
    output logic      [prqa_pkg::FREE_W-1:0]  free_space
);

    import prqa_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    logic              accept;
    logic              s1_move;
    mem_req_t          mem_req;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] ram_rd_data;
    step_result_t      step_result;

    logic              s1_valid_reg;
    step_result_t      s1_result_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic              read_valid_reg;
    logic              packet_accepted_reg;
    logic [FREE_W-1:0] free_space_reg;

    assign s1_move  = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~s1_valid_reg | s1_move;
    assign accept   = in_valid & in_ready;

    prqa_ctrl #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (accept),
        .func           (func),
        .start_of_packet(start_of_packet),
        .packet_length  (packet_length),
        .mem_req        (mem_req),
        .wr_addr        (wr_addr),
        .rd_addr        (rd_addr),
        .result         (step_result)
    );

    prqa_ram #(
        .WIDTH(DATA_W),
        .DEPTH(BUFFER_BYTES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (mem_req.wr_en),
        .wr_addr(wr_addr),
        .wr_data(data_byte),
        .rd_en  (mem_req.rd_en),
        .rd_addr(rd_addr),
        .rd_data(ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_result_reg <= step_result;
        end
        if (s1_move)
        begin
            read_data_reg       <= s1_result_reg.read_valid ? ram_rd_data : '0;
            read_valid_reg      <= s1_result_reg.read_valid;
            packet_accepted_reg <= s1_result_reg.packet_accepted;
            free_space_reg      <= s1_result_reg.free_space;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = read_data_reg;
    assign read_valid      = read_valid_reg;
    assign packet_accepted = packet_accepted_reg;
    assign free_space      = free_space_reg;

    // A word either writes or reads the memory, never both.
    `PRQA_ASSERT_NEVER(a_no_wr_rd_same_word, clk, rst_n, mem_req.wr_en && mem_req.rd_en)
    // Admission keeps one entry free, so a store never makes the pointers meet.
    `PRQA_ASSERT_NEXT(a_write_not_to_empty, clk, rst_n, mem_req.wr_en, wr_addr != rd_addr)
    // A result reports a popped byte or a stored byte, not both.
    `PRQA_ASSERT_NEVER(a_result_exclusive, clk, rst_n, out_valid && read_valid && packet_accepted)
    // A staged result always finds room to move when the output is free.
    `PRQA_ASSERT_NEXT(a_stage_drains, clk, rst_n, s1_valid_reg && !out_valid_reg, out_valid_reg)

endmodule

`default_nettype wire

>>> hdl/prqa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module prqa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/prqa_ctrl.sv
// Pointer, admission and packet byte counter logic of the packet ring queue.
`timescale 1ns / 1ps
`default_nettype none

module prqa_ctrl #(
    parameter int BUFFER_BYTES = 2048
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              step_en,
    input  wire logic                              func,
    input  wire logic                              start_of_packet,
    input  wire logic [prqa_pkg::LEN_W-1:0]        packet_length,
    output prqa_pkg::mem_req_t                     mem_req,
    output logic      [$clog2(BUFFER_BYTES)-1:0]   wr_addr,
    output logic      [$clog2(BUFFER_BYTES)-1:0]   rd_addr,
    output prqa_pkg::step_result_t                 result
);

    import prqa_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam int CW = (FW > LEN_W) ? FW : LEN_W;

    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    rp_reg, rp_next;
    logic             admitted_reg, admitted_next;
    logic [LEN_W-1:0] remaining_reg, remaining_next;
    logic [FW-1:0]    free_now;
    logic [FW-1:0]    free_after;
    logic             wr_en;
    logic             rd_en;
    logic             accepted;
    logic             rvalid;

    function automatic logic [FW-1:0] space_free(input logic [AW-1:0] wp,
                                                  input logic [AW-1:0] rp);
        logic [FW-1:0] space;
        if (rp > wp)
        begin
            space = FW'(rp - wp);
        end
        else if (rp < wp)
        begin
            space = FW'(BUFFER_BYTES) - FW'(wp - rp);
        end
        else
        begin
            space = FW'(BUFFER_BYTES);
        end
        return space;
    endfunction

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        if (p == AW'(BUFFER_BYTES - 1))
        begin
            q = '0;
        end
        else
        begin
            q = p + AW'(1);
        end
        return q;
    endfunction

    assign free_now = space_free(wp_reg, rp_reg);

    always_comb
    begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        admitted_next  = admitted_reg;
        remaining_next = remaining_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        accepted       = 1'b0;
        rvalid         = 1'b0;
        if (func_t'(func) == FUNC_PUSH)
        begin
            if (start_of_packet)
            begin
                admitted_next  = CW'(packet_length) < CW'(free_now);
                remaining_next = packet_length;
            end
            if (remaining_next == '0)
            begin
                admitted_next = 1'b0;
            end
            else
            begin
                if (admitted_next)
                begin
                    wr_en    = 1'b1;
                    accepted = 1'b1;
                    wp_next  = advance(wp_reg);
                end
                remaining_next = remaining_next - LEN_W'(1);
            end
        end
        else
        begin
            if (rp_reg != wp_reg)
            begin
                rd_en   = 1'b1;
                rvalid  = 1'b1;
                rp_next = advance(rp_reg);
            end
        end
        free_after = space_free(wp_next, rp_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            admitted_reg  <= 1'b0;
            remaining_reg <= '0;
        end
        else if (step_en)
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            admitted_reg  <= admitted_next;
            remaining_reg <= remaining_next;
        end
    end

    assign mem_req.wr_en          = step_en & wr_en;
    assign mem_req.rd_en          = step_en & rd_en;
    assign wr_addr                = wp_reg;
    assign rd_addr                = rp_reg;
    assign result.read_valid      = rvalid;
    assign result.packet_accepted = accepted;
    assign result.free_space      = FREE_W'(free_after);

endmodule

`default_nettype wire
